// ----- hdl/pdes_pkg.sv -----
// Shared types, constants and helpers for the projectile drag Euler step block.
// No dependencies.
package pdes_pkg;

    localparam int FRAC_BITS = 16;                 // state fraction bits (8..24)
    localparam int DT_BITS   = 16;                 // time step fraction bits
    localparam int T_W       = 64 - FRAC_BITS;     // width of speed*|v| >> FRAC_BITS
    localparam int KT_W      = 32 + T_W;           // width of K*t
    localparam int ADDR_W    = 5;

    // register indexes
    localparam logic [2:0] REG_DRAG_COEF   = 3'd0;
    localparam logic [2:0] REG_BODY_WIDTH  = 3'd1;
    localparam logic [2:0] REG_BODY_HEIGHT = 3'd2;
    localparam logic [2:0] REG_BODY_MASS   = 3'd3;
    localparam logic [2:0] REG_GRAVITY     = 3'd4;
    localparam logic [2:0] REG_TIME_STEP   = 3'd5;

    localparam logic [7:0]  RST_DRAG_COEF   = 8'd5;
    localparam logic [11:0] RST_BODY_WIDTH  = 12'd16;
    localparam logic [11:0] RST_BODY_HEIGHT = 12'd16;
    localparam logic [15:0] RST_BODY_MASS   = 16'd500;
    localparam logic [15:0] RST_GRAVITY     = 16'd100;
    localparam logic [15:0] RST_TIME_STEP   = 16'd6554;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    typedef struct packed {
        logic [7:0]  drag_coef;
        logic [11:0] body_width;
        logic [11:0] body_height;
        logic [15:0] body_mass;
        logic [15:0] gravity;
        logic [15:0] time_step;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] value;
        logic               clip;
    } sat_t;

    function automatic sat_t sat32(input logic signed [47:0] x);
        sat_t r;
        if (x > 48'sd2147483647)
        begin
            r.value = 32'sh7FFFFFFF;
            r.clip  = 1'b1;
        end
        else if (x < -48'sd2147483648)
        begin
            r.value = 32'sh80000000;
            r.clip  = 1'b1;
        end
        else
        begin
            r.value = x[31:0];
            r.clip  = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- hdl/pdes_in_if.sv -----
// Request channel into the block: op plus the load values.
// Depends on nothing.
interface pdes_in_if;
    logic               valid;
    logic               ready;
    logic               op;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;

    modport source (output valid, op, load_vel_x, load_vel_y, load_pos_x, load_pos_y,
                    input ready);
    modport sink   (input valid, op, load_vel_x, load_vel_y, load_pos_x, load_pos_y,
                    output ready);
endinterface

// ----- hdl/pdes_out_if.sv -----
// Result channel out of the block: state after each request.
// Depends on nothing.
interface pdes_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_vel_x;
    logic signed [31:0] out_vel_y;
    logic               saturated;

    modport source (output valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, saturated,
                    input ready);
    modport sink   (input valid, out_pos_x, out_pos_y, out_vel_x, out_vel_y, saturated,
                     output ready);
endinterface

// ----- hdl/projectile_drag_euler_step_top.sv -----
// Top level: 2-D body under gravity and quadratic drag, one Euler step per tick.
// Depends on pdes_pkg, pdes_in_if, pdes_out_if, pdes_regs.
//
//  channel | dir | handshake        | payload
//  in_ch   | in  | valid/ready      | op, load_vel_x/y, load_pos_x/y
//  out_ch  | out | valid/ready      | out_pos_x/y, out_vel_x/y, saturated
//  apb     | in  | psel/penable     | paddr, pwdata, prdata (pready tied high)
//
// A load request goes straight to ST_DONE. A tick runs the 32-step bit-serial
// square root and two 33-step restoring divides by mass; all multiplies go
// through one registered 33x33 multiplier.
// Reset clears position, velocity and control; registers take their defaults.
// in_ch.ready is high only while idle; a finished result waits in the output
// register while the next request is accepted and worked on. A request that
// finishes while the previous result is still unaccepted holds in ST_DONE.
module projectile_drag_euler_step_top (
    input  logic                        clk,
    input  logic                        rst_n,
    pdes_in_if.sink                     in_ch,
    pdes_out_if.source                  out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pdes_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import pdes_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_SQX, ST_SQY, ST_SQS, ST_ROOT, ST_K1, ST_K2,
        ST_TMUL, ST_KL, ST_KH, ST_KSUM, ST_DIV, ST_DRAG,
        ST_ADT, ST_HALF, ST_VDT, ST_UPD, ST_DONE
    } state_t;

    cfg_t cfg;

    pdes_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    state_t             state_reg;
    logic               axis_reg;          // 0: x, 1: y
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic signed [31:0] ax_reg, ay_reg;
    logic signed [31:0] adt_reg, half_reg;
    logic               sat_reg;
    logic [63:0]        rad_reg;           // sqrt remainder
    logic [63:0]        root_reg;
    logic [5:0]         cnt_reg;
    logic [31:0]        k_reg;
    logic [T_W-1:0]     t_reg;
    logic [63:0]        acc_reg;
    logic [16:0]        rem_reg;
    logic [32:0]        quo_reg;
    logic               cap_reg;
    logic signed [65:0] prod_reg;

    logic               out_valid_reg;
    logic signed [31:0] out_pos_x_reg, out_pos_y_reg, out_vel_x_reg, out_vel_y_reg;
    logic               out_sat_reg;

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;

    logic signed [31:0] v_sel, p_sel, a_sel;
    logic [31:0]        v_mag, ux, uy;
    logic [15:0]        mass;
    logic [63:0]        bit_w, rb;
    logic [KT_W-1:0]    kt;
    logic [17:0]        trial;
    logic [32:0]        mag;
    logic signed [47:0] drag_w, ay_w;
    logic signed [31:0] adt_now, half_now, vdt_now;
    sat_t               s_a, s_pos, s_vel;
    logic               in_acc, out_free;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign in_acc       = in_ch.valid && (state_reg == ST_IDLE);
    assign out_free     = !out_valid_reg || out_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_pos_x = out_pos_x_reg;
    assign out_ch.out_pos_y = out_pos_y_reg;
    assign out_ch.out_vel_x = out_vel_x_reg;
    assign out_ch.out_vel_y = out_vel_y_reg;
    assign out_ch.saturated = out_sat_reg;

    assign ux    = vel_x_reg[31] ? 32'(-vel_x_reg) : 32'(vel_x_reg);
    assign uy    = vel_y_reg[31] ? 32'(-vel_y_reg) : 32'(vel_y_reg);
    assign v_sel = axis_reg ? vel_y_reg : vel_x_reg;
    assign p_sel = axis_reg ? pos_y_reg : pos_x_reg;
    assign a_sel = axis_reg ? ay_reg : ax_reg;
    assign v_mag = axis_reg ? uy : ux;
    assign mass  = (cfg.body_mass == 16'd0) ? 16'd1 : cfg.body_mass;

    // square root step
    assign bit_w = 64'd1 << {cnt_reg[4:0], 1'b0};
    assign rb    = root_reg + bit_w;

    // K*t from two partial products, then restoring divide step
    assign kt    = KT_W'(acc_reg) + {prod_reg[T_W-1:0], 32'd0};
    assign trial = {rem_reg, quo_reg[32]};

    // drag magnitude capped at 2^32, sign opposes velocity
    assign mag    = (cap_reg || (quo_reg > 33'h100000000)) ? 33'h100000000 : quo_reg;
    assign drag_w = v_sel[31] ? 48'(mag) : -48'(mag);
    assign ay_w   = drag_w - (48'(cfg.gravity) << FRAC_BITS);
    assign s_a    = sat32(axis_reg ? ay_w : drag_w);

    assign adt_now  = 32'(prod_reg >>> DT_BITS);
    assign half_now = 32'(prod_reg >>> (DT_BITS + 1));
    assign vdt_now  = 32'(prod_reg >>> DT_BITS);
    assign s_pos    = sat32(48'(p_sel) + 48'(vdt_now) + 48'(half_reg));
    assign s_vel    = sat32(48'(v_sel) + 48'(adt_reg));

    always_comb
    begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        case (state_reg)
            ST_SQX:
            begin
                mul_a = $signed({1'b0, ux});
                mul_b = $signed({1'b0, ux});
            end
            ST_SQY:
            begin
                mul_a = $signed({1'b0, uy});
                mul_b = $signed({1'b0, uy});
            end
            ST_K1:
            begin
                mul_a = $signed(33'(cfg.drag_coef));
                mul_b = $signed(33'(cfg.body_width));
            end
            ST_K2:
            begin
                mul_a = $signed(33'(prod_reg[19:0]));
                mul_b = $signed(33'(cfg.body_height));
            end
            ST_TMUL:
            begin
                mul_a = $signed({1'b0, root_reg[31:0]});
                mul_b = $signed({1'b0, v_mag});
            end
            ST_KL:
            begin
                mul_a = $signed({1'b0, k_reg});
                mul_b = $signed({1'b0, prod_reg[FRAC_BITS+31:FRAC_BITS]});
            end
            ST_KH:
            begin
                mul_a = $signed({1'b0, k_reg});
                mul_b = $signed(33'(t_reg[T_W-1:32]));
            end
            ST_ADT:
            begin
                mul_a = 33'(a_sel);
                mul_b = $signed(33'(cfg.time_step));
            end
            ST_HALF:
            begin
                mul_a = 33'(adt_now);
                mul_b = $signed(33'(cfg.time_step));
            end
            ST_VDT:
            begin
                mul_a = 33'(v_sel);
                mul_b = $signed(33'(cfg.time_step));
            end
            default:
            begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            vel_x_reg     <= '0;
            vel_y_reg     <= '0;
            sat_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        sat_reg  <= 1'b0;
                        axis_reg <= 1'b0;
                        if (in_ch.op == OP_LOAD)
                        begin
                            vel_x_reg <= in_ch.load_vel_x;
                            vel_y_reg <= in_ch.load_vel_y;
                            pos_x_reg <= in_ch.load_pos_x;
                            pos_y_reg <= in_ch.load_pos_y;
                            state_reg <= ST_DONE;
                        end
                        else
                            state_reg <= ST_SQX;
                    end
                end
                ST_SQX: state_reg <= ST_SQY;
                ST_SQY:
                begin
                    acc_reg   <= prod_reg[63:0];
                    state_reg <= ST_SQS;
                end
                ST_SQS:
                begin
                    rad_reg   <= acc_reg + prod_reg[63:0];
                    root_reg  <= '0;
                    cnt_reg   <= 6'd31;
                    state_reg <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    if (rad_reg >= rb)
                    begin
                        rad_reg  <= rad_reg - rb;
                        root_reg <= (root_reg >> 1) + bit_w;
                    end
                    else
                        root_reg <= root_reg >> 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                        state_reg <= ST_K1;
                end
                ST_K1: state_reg <= ST_K2;
                ST_K2: state_reg <= ST_TMUL;
                ST_TMUL:
                begin
                    if (!axis_reg)
                        k_reg <= prod_reg[31:0];
                    state_reg <= ST_KL;
                end
                ST_KL:
                begin
                    t_reg     <= prod_reg[63:FRAC_BITS];
                    state_reg <= ST_KH;
                end
                ST_KH:
                begin
                    acc_reg   <= prod_reg[63:0];
                    state_reg <= ST_KSUM;
                end
                ST_KSUM:
                begin
                    // quotient of 2^33 or more only needs the cap
                    cap_reg   <= (kt[KT_W-1:33] >= (KT_W-33)'(mass));
                    rem_reg   <= 17'(kt[KT_W-1:33]);
                    quo_reg   <= kt[32:0];
                    cnt_reg   <= 6'd32;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (!cap_reg)
                    begin
                        if (trial >= 18'(mass))
                        begin
                            rem_reg <= 17'(trial - 18'(mass));
                            quo_reg <= {quo_reg[31:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= trial[16:0];
                            quo_reg <= {quo_reg[31:0], 1'b0};
                        end
                    end
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == 6'd0)
                        state_reg <= ST_DRAG;
                end
                ST_DRAG:
                begin
                    if (s_a.clip)
                        sat_reg <= 1'b1;
                    if (axis_reg)
                    begin
                        ay_reg    <= s_a.value;
                        axis_reg  <= 1'b0;
                        state_reg <= ST_ADT;
                    end
                    else
                    begin
                        ax_reg    <= s_a.value;
                        axis_reg  <= 1'b1;
                        state_reg <= ST_TMUL;
                    end
                end
                ST_ADT: state_reg <= ST_HALF;
                ST_HALF:
                begin
                    adt_reg   <= adt_now;
                    state_reg <= ST_VDT;
                end
                ST_VDT:
                begin
                    half_reg  <= half_now;
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    if (s_pos.clip || s_vel.clip)
                        sat_reg <= 1'b1;
                    if (axis_reg)
                    begin
                        pos_y_reg <= s_pos.value;
                        vel_y_reg <= s_vel.value;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        pos_x_reg <= s_pos.value;
                        vel_x_reg <= s_vel.value;
                        axis_reg  <= 1'b1;
                        state_reg <= ST_ADT;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pos_x_reg <= pos_x_reg;
                        out_pos_y_reg <= pos_y_reg;
                        out_vel_x_reg <= vel_x_reg;
                        out_vel_y_reg <= vel_y_reg;
                        out_sat_reg   <= sat_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule

// ----- hdl/pdes_regs.sv -----
// APB configuration registers of the drag step block.
// Depends on pdes_pkg.
module pdes_regs (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [pdes_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    output pdes_pkg::cfg_t         cfg
);
    import pdes_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drag_coef   <= RST_DRAG_COEF;
            cfg_reg.body_width  <= RST_BODY_WIDTH;
            cfg_reg.body_height <= RST_BODY_HEIGHT;
            cfg_reg.body_mass   <= RST_BODY_MASS;
            cfg_reg.gravity     <= RST_GRAVITY;
            cfg_reg.time_step   <= RST_TIME_STEP;
        end
        else if (wr)
        begin
            case (idx)
                REG_DRAG_COEF:   cfg_reg.drag_coef   <= pwdata[7:0];
                REG_BODY_WIDTH:  cfg_reg.body_width  <= pwdata[11:0];
                REG_BODY_HEIGHT: cfg_reg.body_height <= pwdata[11:0];
                REG_BODY_MASS:   cfg_reg.body_mass   <= pwdata[15:0];
                REG_GRAVITY:     cfg_reg.gravity     <= pwdata[15:0];
                REG_TIME_STEP:   cfg_reg.time_step   <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_DRAG_COEF:   prdata = {24'd0, cfg_reg.drag_coef};
            REG_BODY_WIDTH:  prdata = {20'd0, cfg_reg.body_width};
            REG_BODY_HEIGHT: prdata = {20'd0, cfg_reg.body_height};
            REG_BODY_MASS:   prdata = {16'd0, cfg_reg.body_mass};
            REG_GRAVITY:     prdata = {16'd0, cfg_reg.gravity};
            REG_TIME_STEP:   prdata = {16'd0, cfg_reg.time_step};
            default:         prdata = 32'd0;
        endcase
    end
endmodule

// ----- verif/pdes_tb_if.sv -----
// Testbench-side note: the channel interfaces come from hdl/pdes_in_if.sv and
// hdl/pdes_out_if.sv; this file holds the shared testbench types. Depends on nothing.
`timescale 1ns / 100ps
package pdes_tb_pkg;

    typedef struct {
        logic               op;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] px;
        logic signed [31:0] py;
    } motion_req_t;

    typedef struct {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               sat;
    } body_state_t;

endpackage

// ----- verif/tb.sv -----
// Self-checking bench for projectile_drag_euler_step_top: random and directed
// load/tick requests, APB register sweeps, per-request state prediction.
// Depends on pdes_pkg, pdes_tb_pkg, pdes_in_if, pdes_out_if and the RTL.
`timescale 1ns / 100ps
module tb;
    import pdes_pkg::*;
    import pdes_tb_pkg::*;

    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pdes_in_if  in_ch();
    pdes_out_if out_ch();

    projectile_drag_euler_step_top i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state and its copy of the registers
    logic [7:0]  m_cd;
    logic [11:0] m_w;
    logic [11:0] m_h;
    logic [15:0] m_mass;
    logic [15:0] m_g;
    logic [15:0] m_dt;
    longint      m_px, m_py, m_vx, m_vy;

    motion_req_t pending_reqs[$];
    body_state_t expected_states[$];
    int          mismatches;
    int          results_seen;
    int          ticks_sent;
    int          loads_sent;
    int          sat_seen;
    int          cfg_sets;
    bit          hold_sender;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Floor shift for signed 64-bit values
    function automatic longint fshr(longint x, int n);
        return x >>> n;
    endfunction

    function automatic longint clip32(longint x, ref bit c);
        if (x > 64'sd2147483647)
        begin
            c = 1'b1;
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            c = 1'b1;
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Drag acceleration on one axis; magnitude capped at 2^32
    function automatic longint drag_accel(logic [63:0] spd, longint v, logic [63:0] k,
                                          logic [63:0] mass);
        logic [63:0]  mag;
        logic [127:0] prod;
        logic [63:0]  t;
        logic [63:0]  m;
        mag  = (v < 0) ? -v : v;
        prod = spd * mag;
        t    = prod[63:0] >> FRAC_BITS;   // product wraps at 64 bits
        if (v == 0)
            return 0;
        prod = k * t;
        if (prod[127:64] != 0)
            m = 64'h1 << 32;
        else
        begin
            m = prod[63:0] / mass;
            if (m > (64'h1 << 32))
                m = 64'h1 << 32;
        end
        return (v > 0) ? -longint'(m) : longint'(m);
    endfunction

    task automatic euler_axis(ref longint p, ref longint v, input longint a, ref bit c);
        longint dt, adt, half, vdt;
        dt   = longint'(m_dt);
        adt  = fshr(a * dt, DT_BITS);
        half = fshr(adt * dt, DT_BITS + 1);
        vdt  = fshr(v * dt, DT_BITS);
        p    = clip32(p + vdt + half, c);
        v    = clip32(v + adt, c);
    endtask

    task automatic predict_motion(input motion_req_t r);
        body_state_t e;
        bit          c;
        logic [63:0] ux, uy, spd, k, mass;
        longint      ax, ay;
        c = 1'b0;
        if (r.op == OP_LOAD)
        begin
            m_vx = r.vx;
            m_vy = r.vy;
            m_px = r.px;
            m_py = r.py;
        end
        else
        begin
            ux   = (m_vx < 0) ? -m_vx : m_vx;
            uy   = (m_vy < 0) ? -m_vy : m_vy;
            spd  = int_sqrt(ux * ux + uy * uy);
            k    = 64'(m_cd) * 64'(m_w) * 64'(m_h);
            mass = (m_mass == 0) ? 64'd1 : 64'(m_mass);
            ax   = clip32(drag_accel(spd, m_vx, k, mass), c);
            ay   = clip32(drag_accel(spd, m_vy, k, mass) - (longint'(m_g) << FRAC_BITS), c);
            euler_axis(m_px, m_vx, ax, c);
            euler_axis(m_py, m_vy, ay, c);
        end
        e.px  = m_px[31:0];
        e.py  = m_py[31:0];
        e.vx  = m_vx[31:0];
        e.vy  = m_vy[31:0];
        e.sat = c;
        expected_states.push_back(e);
    endtask

    // Driver: one request at a time from pending_reqs, random gap per request
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.op         <= OP_TICK;
            in_ch.load_vel_x <= '0;
            in_ch.load_vel_y <= '0;
            in_ch.load_pos_x <= '0;
            in_ch.load_pos_y <= '0;
            gap_left         = $urandom_range(0, 14);
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                // request taken: predict from the payload on the wires
                predict_motion('{in_ch.op, in_ch.load_vel_x, in_ch.load_vel_y,
                                 in_ch.load_pos_x, in_ch.load_pos_y});
                if (in_ch.op == OP_LOAD)
                    loads_sent++;
                else
                    ticks_sent++;
                gap_left = $urandom_range(0, 14);
            end
            if (!in_ch.valid || in_ch.ready)
            begin
                if (gap_left == 0 && pending_reqs.size() > 0 && !hold_sender)
                begin
                    motion_req_t r;
                    r = pending_reqs.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.op         <= r.op;
                    in_ch.load_vel_x <= r.vx;
                    in_ch.load_vel_y <= r.vy;
                    in_ch.load_pos_x <= r.px;
                    in_ch.load_pos_y <= r.py;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                    if (gap_left > 0)
                        gap_left--;
                end
            end
        end
    end

    // Monitor: random stall per result, compare against oldest expectation
    int stall_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_left   = $urandom_range(0, 14);
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                results_seen++;
                if (expected_states.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result with no request outstanding at %0t", $time);
                end
                else
                begin
                    body_state_t e;
                    e = expected_states.pop_front();
                    if (e.sat)
                        sat_seen++;
                    if (out_ch.out_pos_x !== e.px || out_ch.out_pos_y !== e.py ||
                        out_ch.out_vel_x !== e.vx || out_ch.out_vel_y !== e.vy ||
                        out_ch.saturated !== e.sat)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: result %0d exp p=(%h,%h) v=(%h,%h) s=%b got p=(%h,%h) v=(%h,%h) s=%b",
                                     results_seen, e.px, e.py, e.vx, e.vy, e.sat,
                                     out_ch.out_pos_x, out_ch.out_pos_y,
                                     out_ch.out_vel_x, out_ch.out_vel_y, out_ch.saturated);
                    end
                end
                stall_left = $urandom_range(0, 14);
            end
            // long runs with no stall too
            if (stall_left > 0 && !(results_seen % 200 < 20))
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // APB write: setup then access; predictor copy updated at the same edge
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_DRAG_COEF:   m_cd   = val[7:0];
            REG_BODY_WIDTH:  m_w    = val[11:0];
            REG_BODY_HEIGHT: m_h    = val[11:0];
            REG_BODY_MASS:   m_mass = val[15:0];
            REG_GRAVITY:     m_g    = val[15:0];
            REG_TIME_STEP:   m_dt   = val[15:0];
            default: ;
        endcase
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(input logic [7:0] cd, input logic [11:0] w, input logic [11:0] h,
                             input logic [15:0] ms, input logic [15:0] g, input logic [15:0] dt);
        reg_write(REG_DRAG_COEF, {$urandom} & 32'hFFFF_FF00 | cd);
        reg_write(REG_BODY_WIDTH, w);
        reg_write(REG_BODY_HEIGHT, h);
        reg_write(REG_BODY_MASS, ms);
        reg_write(REG_GRAVITY, g);
        reg_write(REG_TIME_STEP, {$urandom} & 32'hFFFF_0000 | dt);
        reg_write(REG_UNMAPPED, $urandom);     // unmapped index, ignored
        cfg_sets++;
    endtask

    // Let the block drain: no request queued or in flight, plus tick latency
    task automatic drain();
        while (pending_reqs.size() > 0 || in_ch.valid || expected_states.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return $urandom;
            default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
        endcase
    endfunction

    task automatic queue_req(input logic op, input logic [31:0] vx, input logic [31:0] vy,
                             input logic [31:0] px, input logic [31:0] py);
        pending_reqs.push_back('{op, vx, vy, px, py});
    endtask

    // A flight: one load with random content, then a run of ticks
    task automatic queue_flight(input int n);
        queue_req(OP_LOAD, pick_val(), pick_val(), pick_val(), pick_val());
        repeat (n)
            queue_req(OP_TICK, $urandom, $urandom, $urandom, $urandom);
    endtask

    initial
    begin
        int phase;
        clk         = 1'b0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        mismatches  = 0;
        results_seen = 0;
        ticks_sent  = 0;
        loads_sent  = 0;
        sat_seen    = 0;
        cfg_sets    = 0;
        hold_sender = 1'b0;
        m_cd   = RST_DRAG_COEF;
        m_w    = RST_BODY_WIDTH;
        m_h    = RST_BODY_HEIGHT;
        m_mass = RST_BODY_MASS;
        m_g    = RST_GRAVITY;
        m_dt   = RST_TIME_STEP;
        m_px = 0; m_py = 0; m_vx = 0; m_vy = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: defaults, ticks from rest, field extremes, zero speed
        queue_req(OP_TICK, 0, 0, 0, 0);
        queue_req(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_req(OP_LOAD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_req(OP_TICK, 0, 0, 0, 0);
        queue_req(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_req(OP_TICK, 0, 0, 0, 0);
        queue_req(OP_LOAD, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0);
        queue_req(OP_TICK, 0, 0, 0, 0);
        queue_req(OP_LOAD, 0, 0, 32'h1234_5678, 32'h8765_4321);
        queue_req(OP_TICK, 0, 0, 0, 0);
        drain();

        // Zero mass and zero time step
        write_all(8'd255, 12'd4095, 12'd4095, 16'd0, 16'd65535, 16'd0);
        queue_req(OP_LOAD, 32'h0100_0000, 32'hFF00_0000, 0, 0);
        queue_req(OP_TICK, 0, 0, 0, 0);
        queue_req(OP_TICK, 0, 0, 0, 0);
        drain();
        // Full step, huge drag, tiny mass: saturates
        write_all(8'd255, 12'd4095, 12'd4095, 16'd1, 16'd65535, 16'd65535);
        queue_req(OP_LOAD, 32'h0100_0000, 32'hFF00_0000, 0, 0);
        queue_req(OP_TICK, 0, 0, 0, 0);
        queue_req(OP_TICK, 0, 0, 0, 0);
        drain();
        // No drag, no gravity
        write_all(8'd0, 12'd0, 12'd0, 16'd65535, 16'd0, 16'd1);
        queue_flight(3);
        drain();

        // Random phases, each with a fresh setting
        for (phase = 0; phase < 12; phase++)
        begin
            if (phase == 0)
                write_all(RST_DRAG_COEF, RST_BODY_WIDTH, RST_BODY_HEIGHT,
                          RST_BODY_MASS, RST_GRAVITY, RST_TIME_STEP);
            else
                write_all(8'($urandom), 12'($urandom), 12'($urandom), 16'($urandom),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 200)),
                          ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 8000)));
            while (pending_reqs.size() < 80)
            begin
                if ($urandom_range(0, 9) < 8)
                    queue_flight($urandom_range(1, 12));
                else
                    queue_req(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                              $urandom);
            end
            if (phase == 5)
            begin
                // sender holds off until every outstanding result is back
                while (pending_reqs.size() > 40)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (in_ch.valid || expected_states.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain();
        end

        $display("Covered %0d ticks and %0d loads over %0d register settings;",
                 ticks_sent, loads_sent, cfg_sets);
        $display("%0d results checked, %0d of them saturating.", results_seen, sat_seen);
        if (mismatches == 0 && expected_states.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: ~1100 requests plus gaps and stalls
    initial
    begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
